[rtl/ac_remote_frame_builder_defines.svh]
// ----------------------------------------------------------------------------
// AC remote frame builder assertion macros
// Shared assertion forms for the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef AC_REMOTE_FRAME_BUILDER_DEFINES_SVH
`define AC_REMOTE_FRAME_BUILDER_DEFINES_SVH

// Checked at every edge outside of reset.
`define AC_RFB_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define AC_RFB_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/ac_rfb_pkg.sv]
// ----------------------------------------------------------------------------
// AC remote frame builder package
// Item types, command codes and the per-format mapping tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ac_rfb_pkg;

   localparam int MAX_FRAME_BYTES = 18;

   // Frame lengths per format.
   localparam logic [4:0] LEN_FMT_18 = 5'd18;
   localparam logic [4:0] LEN_FMT_14 = 5'd14;
   localparam logic [4:0] LEN_FMT_17 = 5'd17;

   // Opcodes.
   localparam logic [1:0] OP_STATE  = 2'd0;
   localparam logic [1:0] OP_TOGGLE = 2'd1;
   localparam logic [1:0] OP_VANE   = 2'd2;
   localparam logic [1:0] OP_BAD    = 2'd3;

   // Frame formats.
   localparam logic [1:0] FMT_18  = 2'd0;
   localparam logic [1:0] FMT_14  = 2'd1;
   localparam logic [1:0] FMT_17  = 2'd2;
   localparam logic [1:0] FMT_BAD = 2'd3;

   // Mode codes and argument limits.
   localparam logic [2:0] MODE_OFF   = 3'd0;
   localparam logic [2:0] MODE_AUTO  = 3'd2;
   localparam logic [2:0] MODE_LIMIT = 3'd6;
   localparam logic [3:0] ARG_POWER_OFF = 4'd0;
   localparam logic [3:0] ARG_TOGGLE_MAX = 4'd6;
   localparam logic [3:0] ARG_EXTRA_MAX  = 4'd10;
   localparam logic [3:0] ARG_VANE_MAX   = 4'd4;
   localparam logic [3:0] ARG_WIDE_BASE  = 4'd4;

   // Fixed header bytes.
   localparam logic [7:0] HDR_0 = 8'h23;
   localparam logic [7:0] HDR_1 = 8'hCB;
   localparam logic [7:0] HDR_2 = 8'h26;
   localparam logic [7:0] HDR_3_AB = 8'h01;
   localparam logic [7:0] HDR_3_C  = 8'h21;
   localparam logic [7:0] FMT_C_BYTE8 = 8'h04;

   // Per-format tables.
   localparam logic [2:0] MODE_A  [0:5] = '{3'd4, 3'd3, 3'd4, 3'd2, 3'd1, 3'd7};
   localparam logic [3:0] B8LOW_A [0:5] = '{4'd0, 4'd6, 4'd0, 4'd2, 4'd0, 4'd7};
   localparam logic [2:0] MODE_B  [0:5] = '{3'd7, 3'd3, 3'd7, 3'd2, 3'd1, 3'd7};
   localparam logic [2:0] FAN_B   [0:3] = '{3'd0, 3'd2, 3'd5, 3'd0};
   localparam logic [2:0] VANE_B  [0:7] = '{3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7, 3'd7};
   localparam logic [3:0] WIDE_B  [0:15] = '{4'd3, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd8, 4'd3,
                                            4'd12, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3};
   localparam logic [2:0] MODE_C  [0:5] = '{3'd3, 3'd1, 3'd3, 3'd5, 3'd2, 3'd0};
   localparam logic [1:0] FAN_C   [0:3] = '{2'd3, 2'd1, 2'd2, 2'd3};
   localparam logic [3:0] VANE_C  [0:7] = '{4'd12, 4'd3, 4'd2, 4'd2, 4'd1, 4'd0, 4'd12, 4'd12};

   // Request item.
   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] command_argument;
      logic [1:0] frame_format;
      logic [2:0] ac_mode;
      logic [7:0] set_temp;
      logic [2:0] fan_speed;
      logic [6:0] feature_bits;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [7:0] frame_byte;
      logic [4:0] byte_index;
      logic       last_byte;
      logic       rejected;
   } rsp_type;

   // Contents of one cell of the byte chain.
   typedef struct packed {
      logic       valid;
      logic       last;
      logic       chk;
      logic       rej;
      logic [4:0] idx;
      logic [7:0] data;
   } cell_type;

endpackage

`default_nettype wire

[rtl/ac_rfb_build.sv]
// ----------------------------------------------------------------------------
// AC remote frame builder: frame assembly
// Maps one request onto the cell contents of a full frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ac_rfb_build (
   input  ac_rfb_pkg::req_type                                   req,
   output ac_rfb_pkg::cell_type [ac_rfb_pkg::MAX_FRAME_BYTES-1:0] frame
);
   import ac_rfb_pkg::*;

   logic       rej;
   logic       power;
   logic [2:0] m;
   logic [1:0] fan;
   logic [2:0] vane;
   logic [3:0] wide;
   logic [3:0] t_ab;
   logic [3:0] t_c;
   logic [2:0] f_a;
   logic [2:0] v_b;
   logic [3:0] w_b;
   logic [3:0] v_c;
   logic [4:0] len;
   logic [7:0] b [MAX_FRAME_BYTES];

   // Validity, power and the derived vane and wide positions.
   always_comb begin
      rej = (req.opcode == OP_BAD) || (req.frame_format == FMT_BAD) ||
            ((req.opcode == OP_STATE) &&
             ((req.ac_mode == MODE_OFF) || (req.ac_mode >= MODE_LIMIT))) ||
            ((req.opcode == OP_TOGGLE) && (req.command_argument > ARG_TOGGLE_MAX)) ||
            ((req.opcode == OP_VANE) && (req.command_argument > ARG_EXTRA_MAX));
      m     = (req.ac_mode < MODE_LIMIT) ? req.ac_mode : MODE_AUTO;
      power = !((req.opcode == OP_TOGGLE) && (req.command_argument == ARG_POWER_OFF));
      fan   = req.fan_speed[1:0];
      vane  = req.feature_bits[1] ? 3'd7 : 3'd0;
      wide  = req.feature_bits[2] ? 4'd8 : 4'd3;
      if (req.opcode == OP_VANE) begin
         if (req.command_argument <= ARG_VANE_MAX) begin
            vane = req.command_argument[2:0] + 3'd1;
         end else begin
            wide = req.command_argument - ARG_WIDE_BASE;
         end
      end
   end

   // Setpoint clamps, as an offset from 16 degrees.
   always_comb begin
      if (req.set_temp < 8'd16) begin
         t_ab = 4'd0;
      end else if (req.set_temp > 8'd31) begin
         t_ab = 4'd15;
      end else begin
         t_ab = req.set_temp[3:0];
      end
      if (req.set_temp < 8'd17) begin
         t_c = 4'd1;
      end else if (req.set_temp > 8'd30) begin
         t_c = 4'd14;
      end else begin
         t_c = req.set_temp[3:0];
      end
   end

   // Table lookups.
   always_comb begin
      f_a = req.feature_bits[4] ? 3'd6 : {1'b0, fan};
      v_b = VANE_B[vane];
      w_b = WIDE_B[wide];
      v_c = VANE_C[vane];
   end

   // Frame bytes per format; the checksum byte is filled in at the chain head.
   always_comb begin
      for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
         b[i] = 8'h00;
      end
      b[0] = HDR_0;
      b[1] = HDR_1;
      b[2] = HDR_2;
      unique case (req.frame_format)
         FMT_18: begin
            len  = LEN_FMT_18;
            b[3] = HDR_3_AB;
            b[5] = power ? 8'h20 : 8'h00;
            b[6] = {1'b0, req.feature_bits[3], MODE_A[m], 3'b000};
            b[7] = {4'h0, t_ab};
            b[8] = {wide, B8LOW_A[m]};
            b[9] = {(f_a == 3'd0), 1'b1, vane, f_a};
            b[14] = req.feature_bits[5] ? 8'h20 : 8'h00;
            b[16] = req.feature_bits[6] ? 8'h02 : 8'h00;
         end
         FMT_14: begin
            len  = LEN_FMT_14;
            b[3] = HDR_3_AB;
            b[5] = power ? 8'h24 : 8'h20;
            b[6] = {5'b00000, MODE_B[m]};
            b[7] = {4'h0, ~t_ab};
            b[8] = {2'b00, v_b, FAN_B[fan]};
            b[12] = {2'b00, w_b, 2'b00};
         end
         FMT_17: begin
            len  = LEN_FMT_17;
            b[3] = HDR_3_C;
            b[5] = power ? 8'h40 : 8'h00;
            b[6] = {t_c, 1'b0, MODE_C[m]};
            b[7] = {v_c, 1'b0, FAN_C[fan], 1'b0};
            b[8] = FMT_C_BYTE8;
            for (int j = 0; j < 6; j++) begin
               b[11 + j] = ~b[5 + j];
            end
         end
         default: begin
            len = 5'd1;
         end
      endcase
   end

   // Cell contents; a rejected request loads a single zero item.
   always_comb begin
      for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
         frame[i].rej  = rej;
         frame[i].idx  = 5'(i);
         if (rej) begin
            frame[i].valid = (i == 0);
            frame[i].last  = (i == 0);
            frame[i].chk   = 1'b0;
            frame[i].data  = 8'h00;
         end else begin
            frame[i].valid = (5'(i) < len);
            frame[i].last  = (5'(i) == len - 5'd1);
            frame[i].chk   = (5'(i) == len - 5'd1) && (req.frame_format != FMT_17);
            frame[i].data  = b[i];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/ac_rfb_cell.sv]
// ----------------------------------------------------------------------------
// AC remote frame builder: chain cell
// Holds one frame byte and hands it to the next cell toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ac_rfb_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  wire                  shift,
   input  ac_rfb_pkg::cell_type load_cell,
   input  ac_rfb_pkg::cell_type next_cell,
   output ac_rfb_pkg::cell_type cur_cell
);
   import ac_rfb_pkg::*;

   cell_type cell_ff;
   cell_type cell_in;

   // A new frame takes priority over shifting.
   always_comb begin
      priority if (load) begin
         cell_in = load_cell;
      end else if (shift) begin
         cell_in = next_cell;
      end else begin
         cell_in = cell_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cur_cell = cell_ff;

endmodule

`default_nettype wire

[rtl/ac_remote_frame_builder.sv]
// ----------------------------------------------------------------------------
// AC remote frame builder
// Turns one remote-control request into the bytes of an IR frame in one of
// three formats, one result item per byte.
// ----------------------------------------------------------------------------
//  Channel  | Ports                          | Direction | Item
//  ---------+--------------------------------+-----------+------------------
//  request  | req_valid, req_stall, req_data | in        | req_type
//  result   | rsp_valid, rsp_stall, rsp_data | out       | rsp_type
//
// A frame of N bytes (18, 14 or 17) leaves at one byte per cycle unless the
// result side stalls; a rejected request yields a single item.
// An accepted request waits in the request register and is loaded into the
// chain in the cycle its predecessor's last byte leaves, so frames follow
// back to back. Bytes leave through chain cell 0 and the output register.
// A stall on the result side stops the chain shifting; synchronous reset empties it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ac_remote_frame_builder_defines.svh"

module ac_remote_frame_builder (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  ac_rfb_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output ac_rfb_pkg::rsp_type rsp_data
);
   import ac_rfb_pkg::*;

   logic     req_full_ff;
   logic     req_full_in;
   req_type  req_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic     advance;
   logic     load;
   logic [7:0] head_byte;
   cell_type [MAX_FRAME_BYTES-1:0] frame;
   cell_type [MAX_FRAME_BYTES-1:0] cells;

   // Chain moves whenever the output register is free or being taken.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign load    = req_full_ff && (!cells[0].valid || (advance && cells[0].last));

   // Request register.
   assign req_stall   = req_full_ff && !load;
   assign req_full_in = (req_valid && !req_stall) || (req_full_ff && !load);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff <= 1'b0;
      end else begin
         req_full_ff <= req_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
   end

   // Frame assembly from the waiting request.
   ac_rfb_build u_build (
      .req   (req_ff),
      .frame (frame)
   );

   // Byte chain, cell 0 at the output end.
   for (genvar g = 0; g < MAX_FRAME_BYTES; g++) begin : g_cell
      cell_type next_cell;
      if (g == MAX_FRAME_BYTES - 1) begin : g_tail
         assign next_cell = '0;
      end else begin : g_mid
         assign next_cell = cells[g + 1];
      end
      ac_rfb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (load),
         .shift     (advance),
         .load_cell (frame[g]),
         .next_cell (next_cell),
         .cur_cell  (cells[g])
      );
   end

   // Running byte sum at the head; it replaces the checksum byte.
   always_comb begin
      head_byte = cells[0].chk ? sum_ff : cells[0].data;
      sum_in    = sum_ff;
      if (advance && cells[0].valid) begin
         sum_in = cells[0].last ? 8'h00 : sum_ff + head_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= 8'h00;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // Output register.
   always_comb begin
      rsp_in.frame_byte = head_byte;
      rsp_in.byte_index = cells[0].idx;
      rsp_in.last_byte  = cells[0].last;
      rsp_in.rejected   = cells[0].rej;
      rsp_valid_in      = advance ? cells[0].valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && cells[0].valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks.
   `AC_RFB_ASSERT(a_chain_packed, !cells[0].valid |-> !cells[1].valid,
      "byte chain has a gap at its head")
   `AC_RFB_ASSERT(a_reject_single, (rsp_valid && rsp_data.rejected) |->
      (rsp_data.last_byte && rsp_data.byte_index == 5'd0),
      "rejected item is not a single last item")
   `AC_RFB_ASSERT(a_sum_cleared, (advance && cells[0].valid && cells[0].last) |=>
      (sum_ff == 8'h00),
      "byte sum not cleared after a frame")
   `AC_RFB_ASSERT(a_next_ready, (rsp_valid && !rsp_data.last_byte) |-> cells[0].valid,
      "frame in progress has no next byte in the chain")

endmodule

`default_nettype wire
